FILE: src/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and codes of the multi-slot timer table.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int unsigned FIELD_TIME_W = 48;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned CNT_W        = 32;

  localparam logic [1:0] OP_ARM     = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_SCAN    = 2'd2;

  localparam logic [1:0] KIND_STATUS    = 2'd0;
  localparam logic [1:0] KIND_EXPIRY    = 2'd1;
  localparam logic [1:0] KIND_SCAN_DONE = 2'd2;

  localparam int unsigned MODE_PERIODIC_BIT = 0;
  localparam int unsigned MODE_ONESHOT_BIT  = 1;

  typedef struct packed {
    logic [1:0]              op;
    logic [SLOT_W-1:0]       slot;
    logic [FIELD_TIME_W-1:0] interval_ticks;
    logic                    periodic_req;
    logic                    oneshot_req;
    logic [FIELD_TIME_W-1:0] now_ticks;
  } mst_in_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SLOT_W-1:0]       timer_slot;
    logic                    status;
    logic [CNT_W-1:0]        fire_count;
    logic [FIELD_TIME_W-1:0] next_wake;
    logic                    last;
  } mst_out_t;

  typedef struct packed {
    logic tim_we;
    logic cnt_we;
    logic cnt_clr;
  } mst_mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END
  } mst_state_e;

endpackage

FILE: src/mst_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_chan_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface mst_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/mst_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_slot_store
// Per-slot timing RAM (interval, expiry) and expiry count RAM with valid bits.
// ----------------------------------------------------------------------------
module mst_slot_store #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned TW    = 48,
  parameter int unsigned AW    = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mst_pkg::mst_mem_ctl_t      ctl_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [TW-1:0]              wr_dur_i,
  input  logic [TW-1:0]              wr_exp_i,
  input  logic [mst_pkg::CNT_W-1:0]  wr_cnt_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [TW-1:0]              rd_dur_o,
  output logic [TW-1:0]              rd_exp_o,
  output logic [mst_pkg::CNT_W-1:0]  rd_cnt_o
);
  import mst_pkg::*;

  logic [2*TW-1:0]  tim_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0] cnt_vld_q;
  logic [2*TW-1:0]  tim_rd_q;
  logic [CNT_W-1:0] cnt_rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.tim_we) begin
      tim_mem[wr_addr_i] <= {wr_dur_i, wr_exp_i};
    end
    if (ctl_i.cnt_we) begin
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
    tim_rd_q <= tim_mem[rd_addr_i];
    cnt_rd_q <= cnt_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (ctl_i.cnt_we) begin
        cnt_vld_q[wr_addr_i] <= 1'b1;
      end else if (ctl_i.cnt_clr) begin
        cnt_vld_q[wr_addr_i] <= 1'b0;
      end
      rd_vld_q <= cnt_vld_q[rd_addr_i];
    end
  end

  assign rd_dur_o = tim_rd_q[2*TW-1:TW];
  assign rd_exp_o = tim_rd_q[TW-1:0];
  assign rd_cnt_o = rd_vld_q ? cnt_rd_q : '0;

endmodule

FILE: src/multi_slot_timer_table.sv
`timescale 1ns / 1ps
// Arm and destroy: the status word appears the cycle after the request is
// accepted; ignored words produce no result word.
// Scan: one slot per cycle through the slot RAM read/modify/write loop, except
// while the result side stalls an expiry word.
// Throughput: one arm or destroy per cycle while the result side is not stalled; a scan blocks input until done.
// Reset: asynchronous, clears all marks, counts and the minimum; no sweep.
// ----------------------------------------------------------------------------
// multi_slot_timer_table
// Timer slot table with arm, destroy and scan-with-expiry operations.
// ----------------------------------------------------------------------------
module multi_slot_timer_table #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned TIME_WIDTH  = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mst_chan_if.sink          req_i,
  mst_chan_if.source        rsp_o
);
  import mst_pkg::*;

  localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned TW = TIME_WIDTH;

  mst_state_e state_q, state_d;

  logic [TIMER_SLOTS-1:0] armed_q;
  logic [TIMER_SLOTS-1:0] deleted_q;
  logic [1:0]             mode_q [TIMER_SLOTS];
  logic [SW-1:0]          idx_q;
  logic [TW-1:0]          now_q;
  logic [TW-1:0]          min_q;
  logic                   out_vld_q;
  mst_out_t               out_q;

  mst_in_t      req;
  logic         accept;
  logic         out_busy;
  logic         in_range;
  logic [SW-1:0] slot_idx;
  logic [TW-1:0] req_ivl;
  logic [TW-1:0] req_now;
  logic         arm_bad;

  logic [TW-1:0]    rd_dur;
  logic [TW-1:0]    rd_exp;
  logic [CNT_W-1:0] rd_cnt;

  logic          cur_arm;
  logic          cur_del;
  logic          cur_per;
  logic          fire;
  logic          stall;
  logic          take;
  logic [CNT_W-1:0] cnt_inc;

  mst_mem_ctl_t  mem_ctl;
  logic [SW-1:0] wr_addr;
  logic [TW-1:0] wr_dur;
  logic [TW-1:0] wr_exp;
  logic [SW-1:0] rd_addr;
  logic          out_load;
  mst_out_t      out_d;

  assign req      = req_i.payload;
  assign out_busy = out_vld_q && !rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && !out_busy;
  assign accept   = req_i.valid && req_i.ready;
  assign in_range = 32'(req.slot) < TIMER_SLOTS;
  assign slot_idx = SW'(req.slot);
  assign req_ivl  = TW'(req.interval_ticks);
  assign req_now  = TW'(req.now_ticks);
  assign arm_bad  = !in_range || (req_ivl == '0) || (req.periodic_req == req.oneshot_req)
                    || deleted_q[slot_idx];

  assign cur_arm = armed_q[idx_q];
  assign cur_del = deleted_q[idx_q];
  assign cur_per = mode_q[idx_q][MODE_PERIODIC_BIT];
  assign fire    = cur_arm && !cur_del && (now_q >= rd_exp);
  assign stall   = fire && out_busy;
  assign take    = cur_arm && !cur_del && (!fire || cur_per);
  assign cnt_inc = rd_cnt + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req.op == OP_SCAN) begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!stall && idx_q == '0) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (!out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl  = '0;
    wr_addr  = idx_q;
    wr_dur   = rd_dur;
    wr_exp   = TW'(now_q + rd_dur);
    rd_addr  = idx_q;
    out_load = 1'b0;
    out_d    = '0;
    unique case (state_q)
      ST_IDLE: begin
        wr_addr = slot_idx;
        wr_dur  = req_ivl;
        wr_exp  = TW'(req_now + req_ivl);
        if (accept && (req.op == OP_ARM || req.op == OP_DESTROY)) begin
          out_load         = 1'b1;
          out_d.kind       = KIND_STATUS;
          out_d.timer_slot = req.slot;
          out_d.last       = 1'b1;
          if (req.op == OP_ARM) begin
            out_d.status   = arm_bad;
            mem_ctl.tim_we = !arm_bad;
          end else begin
            out_d.status = !in_range;
          end
        end
      end
      ST_SCAN_RD: ;
      ST_SCAN_EV: begin
        if (!stall) begin
          if (idx_q != '0) begin
            rd_addr = idx_q - 1'b1;
          end
          mem_ctl.cnt_clr = cur_del;
          if (fire) begin
            mem_ctl.cnt_we   = 1'b1;
            mem_ctl.tim_we   = cur_per;
            out_load         = 1'b1;
            out_d.kind       = KIND_EXPIRY;
            out_d.timer_slot = SLOT_W'(idx_q);
            out_d.fire_count = cnt_inc;
          end
        end
      end
      ST_SCAN_END: begin
        if (!out_busy) begin
          out_load        = 1'b1;
          out_d.kind      = KIND_SCAN_DONE;
          out_d.next_wake = FIELD_TIME_W'(min_q);
          out_d.last      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  mst_slot_store #(
    .SLOTS (TIMER_SLOTS),
    .TW    (TW),
    .AW    (SW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_dur_i  (wr_dur),
    .wr_exp_i  (wr_exp),
    .wr_cnt_i  (cnt_inc),
    .rd_addr_i (rd_addr),
    .rd_dur_o  (rd_dur),
    .rd_exp_o  (rd_exp),
    .rd_cnt_o  (rd_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      armed_q   <= '0;
      deleted_q <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        mode_q[i] <= '0;
      end
      idx_q     <= '0;
      min_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_range) begin
        if (req.op == OP_ARM && !arm_bad) begin
          armed_q[slot_idx] <= 1'b1;
          mode_q[slot_idx]  <= mode_q[slot_idx] | {req.oneshot_req, req.periodic_req};
        end else if (req.op == OP_DESTROY) begin
          armed_q[slot_idx]   <= 1'b0;
          deleted_q[slot_idx] <= 1'b1;
        end
      end
      if (accept && req.op == OP_SCAN) begin
        idx_q <= SW'(TIMER_SLOTS - 1);
        min_q <= '0;
      end
      if (state_q == ST_SCAN_EV && !stall) begin
        if (idx_q != '0) begin
          idx_q <= idx_q - 1'b1;
        end
        if (cur_del) begin
          deleted_q[idx_q] <= 1'b0;
          armed_q[idx_q]   <= 1'b0;
          mode_q[idx_q]    <= '0;
        end else if (fire && !cur_per) begin
          armed_q[idx_q] <= 1'b0;
        end
        if (take && (min_q == '0 || min_q > rd_dur)) begin
          min_q <= rd_dur;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req.op == OP_SCAN) begin
      now_q <= req_now;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

endmodule

FILE: src/mst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_op,
  input logic              out_valid,
  input logic              out_ready,
  input mst_pkg::mst_out_t out_word
);
  import mst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_status_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op == OP_ARM || in_op == OP_DESTROY)
    |=> out_valid && out_word.kind == KIND_STATUS && out_word.last)
    else $error("arm/destroy status word missing");

  a_expiry_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_word.kind == KIND_EXPIRY
    |-> !out_word.last && !out_word.status && out_word.next_wake == '0)
    else $error("malformed expiry word");

  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_word.kind == KIND_SCAN_DONE
    |-> out_word.last && out_word.timer_slot == '0 && out_word.fire_count == '0)
    else $error("malformed scan done word");

endmodule

bind multi_slot_timer_table mst_checker u_mst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .in_op     (req_i.payload.op),
  .out_valid (rsp_o.valid),
  .out_ready (rsp_o.ready),
  .out_word  (rsp_o.payload)
);
